// ----- rtl/cmt_pkg.sv -----
// Package for the client MAC table: field widths, operation and status codes.
// No dependencies.
package cmt_pkg;

  localparam int MAC_W               = 48;
  localparam int OP_W                = 2;
  localparam int INDEX_W             = 3;
  localparam int COUNT_OUT_W         = 4;
  localparam int STATUS_W            = 2;
  localparam int DEFAULT_TABLE_DEPTH = 8;

  localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_JOIN   = 2'd1,
    OP_LEAVE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_MOVE   = 5'b00100,
    S_RDCAP  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

endpackage

// ----- rtl/cmt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/client_mac_table.sv -----
// Client MAC table: up to TABLE_DEPTH station addresses, kept packed in slots
// below a live count, with lookup, join, leave and read-entry operations.
// Depends on cmt_pkg and cmt_ram.
//
// One item is worked at a time. Lookup, join and leave scan the table through
// the single read port of the address RAM with one 48-bit comparator, one slot
// per cycle, stopping at the first match; a leave that hits then moves the last
// entry into the freed slot. A read-entry item reads its slot and captures the
// entry if the index is below the count. The result sits in an output register,
// so a result not yet taken stalls the next item only in its result state.
module client_mac_table
  import cmt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        op,
  input  logic [MAC_W-1:0]       client_mac,
  input  logic [INDEX_W-1:0]     entry_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic [MAC_W-1:0]       entry_mac,
  output logic                   entry_valid,
  output logic [STATUS_W-1:0]    status
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IW   = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int SW   = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  state_t              state, state_next;
  op_t                 op_r, op_r_next;
  logic [MAC_W-1:0]    mac_r, mac_r_next;
  logic [INDEX_W-1:0]  idx_r, idx_r_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       scan_idx, scan_idx_next;
  logic                cmp_valid, cmp_valid_next;
  logic [AW-1:0]       cmp_idx, cmp_idx_next;
  logic [AW-1:0]       slot, slot_next;
  logic                found_r, found_r_next;
  status_t             status_r, status_r_next;
  logic                evalid_r, evalid_r_next;
  logic [MAC_W-1:0]    emac_r, emac_r_next;

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [MAC_W-1:0]    ram_wr_data;
  logic [AW-1:0]       ram_rd_addr;
  logic [MAC_W-1:0]    ram_rd_data;

  logic                hit;
  logic [CW-1:0]       count_dec;
  logic [SW-1:0]       count_ext;
  logic                out_load;

  cmt_ram #(
    .WIDTH (MAC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready  = (state == S_IDLE);
  assign hit       = cmp_valid && (ram_rd_data == mac_r);
  assign count_dec = count - CW'(1);
  assign count_ext = SW'(count);
  assign out_load  = (state == S_RESULT) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    op_r_next      = op_r;
    mac_r_next     = mac_r;
    idx_r_next     = idx_r;
    count_next     = count;
    scan_idx_next  = scan_idx;
    cmp_valid_next = cmp_valid;
    cmp_idx_next   = cmp_idx;
    slot_next      = slot;
    found_r_next   = found_r;
    status_r_next  = status_r;
    evalid_r_next  = evalid_r;
    emac_r_next    = emac_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count[AW-1:0];
    ram_wr_data    = mac_r;
    ram_rd_addr    = AW'(entry_index);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next      = op_t'(op);
          mac_r_next     = client_mac;
          idx_r_next     = entry_index;
          scan_idx_next  = '0;
          cmp_valid_next = 1'b0;
          found_r_next   = 1'b0;
          status_r_next  = ST_DONE;
          evalid_r_next  = 1'b0;
          emac_r_next    = '0;
          state_next     = (op_t'(op) == OP_READ) ? S_RDCAP : S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          found_r_next   = 1'b1;
          slot_next      = cmp_idx;
          cmp_valid_next = 1'b0;
          ram_rd_addr    = count_dec[AW-1:0];
          state_next     = S_RESULT;
          case (op_r)
            OP_JOIN:  status_r_next = ST_PRESENT;
            OP_LEAVE: begin
              count_next = count_dec;
              state_next = S_MOVE;
            end
            default:  status_r_next = ST_DONE;
          endcase
        end else if (scan_idx < count) begin
          ram_rd_addr    = scan_idx[AW-1:0];
          cmp_valid_next = 1'b1;
          cmp_idx_next   = scan_idx[AW-1:0];
          scan_idx_next  = scan_idx + CW'(1);
        end else begin
          cmp_valid_next = 1'b0;
          state_next     = S_RESULT;
          case (op_r)
            OP_JOIN: begin
              if (count < CW'(TABLE_DEPTH)) begin
                ram_wr_en     = 1'b1;
                count_next    = count + CW'(1);
                status_r_next = ST_DONE;
              end else begin
                status_r_next = ST_FULL;
              end
            end
            default: status_r_next = ST_ABSENT;
          endcase
        end
      end

      S_MOVE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = slot;
        ram_wr_data = ram_rd_data;
        state_next  = S_RESULT;
      end

      S_RDCAP: begin
        if (IW'(idx_r) < IW'(count)) begin
          evalid_r_next = 1'b1;
          emac_r_next   = ram_rd_data;
          status_r_next = ST_DONE;
        end else begin
          status_r_next = ST_ABSENT;
        end
        state_next = S_RESULT;
      end

      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    mac_r    <= mac_r_next;
    idx_r    <= idx_r_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    slot     <= slot_next;
    found_r  <= found_r_next;
    status_r <= status_r_next;
    evalid_r <= evalid_r_next;
    emac_r   <= emac_r_next;
    if (out_load) begin
      found       <= found_r;
      entry_count <= (count_ext > SW'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                      : count_ext[COUNT_OUT_W-1:0];
      entry_mac   <= emac_r;
      entry_valid <= evalid_r;
      status      <= status_r;
    end
  end

endmodule
